@@ src/hbsb_pkg.sv @@
// shared types and constants for the histogram binning engine
// used by the top module, front end, queue and back end; depends on nothing

package hbsb_pkg;

  // default sizes, handed down from the top level parameters
  localparam int unsigned MaxBinsDef   = 256;
  localparam int unsigned CountBitsDef = 32;

  // entries in the queue between front and back end
  localparam int unsigned QueueDepth = 2;

  // field widths of the stream payload
  localparam int unsigned IdxW   = 8;
  localparam int unsigned ValW   = 32;
  localparam int unsigned OutCntW = 32;
  localparam int unsigned CfgW   = 9;
  localparam logic [CfgW-1:0] CfgReset = 9'd256;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BIN   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } hbsb_op_e;

  // decoded command passed from front to back
  typedef struct packed {
    hbsb_op_e          op;
    logic [IdxW-1:0]   idx;
    logic              idx_ok;
    logic [ValW-1:0]   value;
  } hbsb_cmd_t;

endpackage

@@ src/histogram_binary_search_binning_core.sv @@
// histogram engine with binary search binning. items enter on the slave stream: tuser carries
// the mode (load bound, bin a sample, read a count, clear all counts), tdata the bin index and
// the unsigned q16.16 value. every item gives exactly one result item on the master stream.
// the front end registers and decodes items into a two-entry queue, so the input keeps
// flowing while the back end works or a result waits; the back end runs one item at a time.
// a sample enters the search state, which probes the bound memory by binary search (at most
// ceil(log2(bins_in_use + 1)) probes, nine for 256 bins), then goes on to the count update.
// a load registers its result as it is taken, a read passes through the read state, and a
// clear sweeps the count memory one entry per cycle. after reset the same sweep runs over
// the count memory before the back end takes its first item; the front end still takes
// items meanwhile. bounds must be written before they are searched and should ascend.
// counts saturate. bins_in_use is to be written by the user only while the block is idle;
// the block itself does not enforce this. zero acts as one.
// depends on hbsb_pkg, hbsb_front, hbsb_queue, hbsb_back

module histogram_binary_search_binning_core
  import hbsb_pkg::*;
#(
  parameter int unsigned MAX_BINS   = MaxBinsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration: bins_in_use
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  // input items
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [39:0]     s_axis_tdata,   // bin_index [7:0], sample_value [39:8]
  input  logic [1:0]      s_axis_tuser,   // mode [1:0]
  // result items
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [39:0]     m_axis_tdata,   // matched_bin [7:0], bin_count [39:8]
  output logic            m_axis_tuser    // was_binned [0]
);

  localparam int unsigned CW = $clog2(MAX_BINS + 1);

  logic [CfgW-1:0] bins_in_use_q;
  logic [CW-1:0]   active_bins;

  logic      f_vld, f_rdy;
  hbsb_cmd_t f_cmd;
  logic      b_vld, b_rdy;
  hbsb_cmd_t b_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_in_use_q <= CfgReset;
    end else if (cfg_we_i) begin
      bins_in_use_q <= cfg_wdata_i;
    end
  end

  // zero acts as one, anything past the table depth is clipped
  always_comb begin
    if (bins_in_use_q == '0) begin
      active_bins = CW'(1);
    end else if (32'(bins_in_use_q) > MAX_BINS) begin
      active_bins = CW'(MAX_BINS);
    end else begin
      active_bins = CW'(bins_in_use_q);
    end
  end

  hbsb_front #(
    .MAX_BINS(MAX_BINS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .cmd_vld_o(f_vld),
    .cmd_rdy_i(f_rdy),
    .cmd_o    (f_cmd)
  );

  hbsb_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_vld_i(f_vld),
    .push_rdy_o(f_rdy),
    .push_cmd_i(f_cmd),
    .pop_vld_o (b_vld),
    .pop_rdy_i (b_rdy),
    .pop_cmd_o (b_cmd)
  );

  hbsb_back #(
    .MAX_BINS  (MAX_BINS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cmd_vld_i    (b_vld),
    .cmd_rdy_o    (b_rdy),
    .cmd_i        (b_cmd),
    .active_bins_i(active_bins),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

endmodule

@@ src/hbsb_front.sv @@
// front end: input item register and command decode
// depends on hbsb_pkg

module hbsb_front
  import hbsb_pkg::*;
#(
  parameter int unsigned MAX_BINS = MaxBinsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [39:0]            s_axis_tdata,  // bin_index [7:0], sample_value [39:8]
  input  logic [1:0]             s_axis_tuser,  // mode [1:0]
  output logic                   cmd_vld_o,
  input  logic                   cmd_rdy_i,
  output hbsb_cmd_t              cmd_o
);

  logic      vld_q;
  hbsb_cmd_t cmd_q;
  hbsb_cmd_t cmd_d;

  assign s_axis_tready = !vld_q || cmd_rdy_i;
  assign cmd_vld_o     = vld_q;
  assign cmd_o         = cmd_q;

  always_comb begin
    cmd_d.op     = hbsb_op_e'(s_axis_tuser);
    cmd_d.idx    = s_axis_tdata[IdxW-1:0];
    cmd_d.idx_ok = (32'(s_axis_tdata[IdxW-1:0]) < MAX_BINS);
    cmd_d.value  = s_axis_tdata[IdxW+ValW-1:IdxW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

@@ src/hbsb_queue.sv @@
// small command queue between front and back end
// depends on hbsb_pkg

module hbsb_queue
  import hbsb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_vld_i,
  output logic      push_rdy_o,
  input  hbsb_cmd_t push_cmd_i,
  output logic      pop_vld_o,
  input  logic      pop_rdy_i,
  output hbsb_cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  hbsb_cmd_t       slot_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_rdy_o = (cnt_q != CntW'(QueueDepth));
  assign pop_vld_o  = (cnt_q != '0);
  assign pop_cmd_o  = slot_q[rd_q];
  assign push       = push_vld_i && push_rdy_o;
  assign pop        = pop_vld_o && pop_rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

@@ src/hbsb_back.sv @@
// back end: bound and count memories, binary search sequencer, result register
// depends on hbsb_pkg

module hbsb_back
  import hbsb_pkg::*;
#(
  parameter int unsigned MAX_BINS   = MaxBinsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef,
  localparam int unsigned AW = $clog2(MAX_BINS),
  localparam int unsigned CW = $clog2(MAX_BINS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_vld_i,
  output logic          cmd_rdy_o,
  input  hbsb_cmd_t     cmd_i,
  input  logic [CW-1:0] active_bins_i,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [39:0]   m_axis_tdata,   // matched_bin [7:0], bin_count [39:8]
  output logic          m_axis_tuser    // was_binned
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SRCH,
    ST_UPD,
    ST_RDC,
    ST_CLR
  } state_e;

  state_e state_q;

  logic [ValW-1:0]       bound_mem [MAX_BINS];
  logic [COUNT_BITS-1:0] count_mem [MAX_BINS];

  logic [ValW-1:0]       bnd_q, bprev_q;
  logic [COUNT_BITS-1:0] cnt_q;

  logic [CW-1:0]   lo_q, hiex_q;
  logic [AW-1:0]   mid_q, clr_q;
  logic [ValW-1:0] x_q;
  logic            rd_ok_q;

  logic              out_vld_q, out_hit_q;
  logic [IdxW-1:0]   out_bin_q;
  logic [OutCntW-1:0] out_cnt_q;

  logic                  out_free, pop, hit, go_right, empty_n, res_vld;
  logic [AW-1:0]         mid0, mid_n, b_raddr, c_raddr, c_waddr;
  logic [CW-1:0]         lo_n, hiex_n;
  logic                  c_we;
  logic [COUNT_BITS-1:0] c_wdata, cnt_inc;

  assign out_free  = !out_vld_q || m_axis_tready;
  assign cmd_rdy_o = (state_q == ST_IDLE) && out_free;
  assign pop       = cmd_rdy_o && cmd_vld_i;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_cnt_q, out_bin_q};
  assign m_axis_tuser  = out_hit_q;

  // one search step on the bounds read for the current probe
  always_comb begin
    mid0     = AW'((active_bins_i - CW'(1)) >> 1);
    hit      = (x_q <= bnd_q) && ((mid_q == '0) || (x_q > bprev_q));
    go_right = (x_q > bnd_q);
    lo_n     = go_right ? (CW'(mid_q) + CW'(1)) : lo_q;
    hiex_n   = go_right ? hiex_q : CW'(mid_q);
    empty_n  = (lo_n >= hiex_n);
    mid_n    = AW'(lo_n + ((hiex_n - lo_n - CW'(1)) >> 1));
    b_raddr  = (state_q == ST_SRCH) ? mid_n : mid0;
    c_raddr  = (state_q == ST_SRCH) ? mid_q : AW'(cmd_i.idx);
  end

  // a result is registered in this cycle
  assign res_vld = (pop && (cmd_i.op == OP_LOAD))
                || ((state_q == ST_SRCH) && !hit && empty_n)
                || (state_q == ST_UPD)
                || (state_q == ST_RDC)
                || ((state_q == ST_CLR) && (clr_q == AW'(MAX_BINS - 1)));

  // saturating increment and count write port
  always_comb begin
    cnt_inc = (&cnt_q) ? cnt_q : cnt_q + COUNT_BITS'(1);
    c_we    = (state_q == ST_UPD) || (state_q == ST_INIT) || (state_q == ST_CLR);
    c_waddr = (state_q == ST_UPD) ? mid_q : clr_q;
    c_wdata = (state_q == ST_UPD) ? cnt_inc : '0;
  end

  always_ff @(posedge clk_i) begin
    if (pop && (cmd_i.op == OP_LOAD) && cmd_i.idx_ok) begin
      bound_mem[AW'(cmd_i.idx)] <= cmd_i.value;
    end
    bnd_q   <= bound_mem[b_raddr];
    bprev_q <= bound_mem[b_raddr - AW'(1)];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      count_mem[c_waddr] <= c_wdata;
    end
    cnt_q <= count_mem[c_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      lo_q      <= '0;
      hiex_q    <= '0;
      mid_q     <= '0;
      x_q       <= '0;
      clr_q     <= '0;
      rd_ok_q   <= 1'b0;
      out_vld_q <= 1'b0;
      out_hit_q <= 1'b0;
      out_bin_q <= '0;
      out_cnt_q <= '0;
    end else begin
      out_vld_q <= res_vld || (out_vld_q && !m_axis_tready);
      case (state_q)
        ST_INIT: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MAX_BINS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            case (cmd_i.op)
              OP_LOAD: begin
                out_hit_q <= 1'b0;
                out_bin_q <= '0;
                out_cnt_q <= '0;
              end
              OP_BIN: begin
                lo_q    <= '0;
                hiex_q  <= active_bins_i;
                mid_q   <= mid0;
                x_q     <= cmd_i.value;
                state_q <= ST_SRCH;
              end
              OP_READ: begin
                rd_ok_q <= cmd_i.idx_ok;
                state_q <= ST_RDC;
              end
              default: begin
                clr_q   <= '0;
                state_q <= ST_CLR;
              end
            endcase
          end
        end
        ST_SRCH: begin
          if (hit) begin
            state_q <= ST_UPD;
          end else if (empty_n) begin
            out_hit_q <= 1'b0;
            out_bin_q <= '0;
            out_cnt_q <= '0;
            state_q   <= ST_IDLE;
          end else begin
            lo_q   <= lo_n;
            hiex_q <= hiex_n;
            mid_q  <= mid_n;
          end
        end
        ST_UPD: begin
          out_hit_q <= 1'b1;
          out_bin_q <= IdxW'(mid_q);
          out_cnt_q <= '0;
          state_q   <= ST_IDLE;
        end
        ST_RDC: begin
          out_hit_q <= 1'b0;
          out_bin_q <= '0;
          out_cnt_q <= rd_ok_q ? OutCntW'(cnt_q) : '0;
          state_q   <= ST_IDLE;
        end
        ST_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MAX_BINS - 1)) begin
            out_hit_q <= 1'b0;
            out_bin_q <= '0;
            out_cnt_q <= '0;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/hbsb_checker.sv @@
// port level checks on the result stream of the histogram engine
// depends on histogram_binary_search_binning_core, attached by bind

module hbsb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result stays offered
  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // an unbinned or non-bin result reports bin zero
  a_bin_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
    else $error("matched bin set without was_binned");

  // a binned sample never carries a count
  a_cnt_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[39:8] == 32'd0)
    else $error("bin count set on a binned sample");

endmodule

bind histogram_binary_search_binning_core hbsb_checker u_hbsb_checker (.*);

@@ sim/histogram_binary_search_binning_core_test.sv @@
// self-checking testbench for histogram_binary_search_binning_core: bound loads, sample
// binning, count reads and clears, checked against a predictor of the histogram in this file
// depends on hbsb_pkg and the rtl of histogram_binary_search_binning_core

module histogram_binary_search_binning_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hbsb_pkg::*;

  localparam int unsigned NumBins  = 256;
  localparam int unsigned SettleCycles = 300;   // covers a clear sweep of the count store

  // one result item as the block reports it
  typedef struct packed {
    logic [7:0]  bin;
    logic        hit;
    logic [31:0] count;
  } bin_result_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [39:0]     s_axis_tdata;   // bin_index [7:0], sample_value [39:8]
  logic [1:0]      s_axis_tuser;   // mode [1:0]
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [39:0]     m_axis_tdata;   // matched_bin [7:0], bin_count [39:8]
  logic            m_axis_tuser;   // was_binned [0]

  // histogram state as the block should hold it
  bit   [31:0]     bound_mem [NumBins];
  bit   [31:0]     count_mem [NumBins];
  logic [CfgW-1:0] bins_setting = CfgReset;

  bin_result_t pending_results[$];

  // stimulus shaping, shared with the driver processes
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int recv_holdoff = 0;

  // bookkeeping
  int mismatches = 0;
  int n_loads = 0;
  int n_samples = 0;
  int n_binned = 0;
  int n_reads = 0;
  int n_clears = 0;
  int n_results = 0;
  int n_settings = 0;

  histogram_binary_search_binning_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

  // number of bins the search covers: zero acts as one, anything past the table saturates
  function automatic int bins_active();
    if (bins_setting == '0) return 1;
    if (bins_setting > NumBins) return NumBins;
    return int'(bins_setting);
  endfunction

  // advance the histogram by one accepted item and return the result it must produce
  function automatic bin_result_t histogram_step(hbsb_op_e op, logic [7:0] idx,
                                                 logic [31:0] value);
    bin_result_t res;
    int lo;
    int hi;
    int mid;
    bit found;
    res = '0;
    case (op)
      OP_LOAD: begin
        bound_mem[idx] = value;
      end
      OP_BIN: begin
        lo = 0;
        hi = bins_active() - 1;
        found = 1'b0;
        // probe the midpoint, go right when the sample lies above the probed bound
        while (!found && lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (value <= bound_mem[mid] && (mid == 0 || value > bound_mem[mid-1])) begin
            found = 1'b1;
          end else if (value > bound_mem[mid]) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
        if (found) begin
          if (count_mem[mid] != '1) count_mem[mid]++;   // saturating count
          res.bin = mid[7:0];
          res.hit = 1'b1;
        end
      end
      OP_READ: begin
        res.count = count_mem[idx];
      end
      default: begin
        foreach (count_mem[i]) count_mem[i] = '0;
      end
    endcase
    return res;
  endfunction

  // offer one item, wait for its handshake, then record what it must produce
  task automatic send_item(hbsb_op_e op, logic [7:0] idx, logic [31:0] value);
    bin_result_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value, idx};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    res = histogram_step(op, idx, value);
    pending_results = {pending_results, res};
    case (op)
      OP_LOAD:  n_loads++;
      OP_BIN: begin
        n_samples++;
        if (res.hit) n_binned++;
      end
      OP_READ:  n_reads++;
      default:  n_clears++;
    endcase
  endtask

  // stop offering and wait until every result has come back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // bins_in_use is only written with the block idle
  task automatic write_bins_in_use(logic [CfgW-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    bins_setting = value;
    n_settings++;
  endtask

  // a sample aimed at the edges of a bin in use, now and then anywhere
  function automatic logic [31:0] pick_sample();
    int j;
    longint span;
    j = $urandom_range(bins_active() - 1);
    case ($urandom_range(7))
      0: return bound_mem[j];
      1: return bound_mem[j] + 32'd1;
      2: return bound_mem[j] - 32'd1;
      3: begin
        span = (j == 0) ? longint'(bound_mem[0]) + 1
                        : longint'(bound_mem[j]) - longint'(bound_mem[j-1]);
        if (span <= 0) return bound_mem[j];
        return bound_mem[j] - 32'(longint'($urandom) % span);
      end
      4: return $urandom;
      5: return 32'd0;
      6: return 32'hFFFF_FFFF;
      default: return bound_mem[bins_active() - 1] + 32'($urandom_range(16));
    endcase
  endfunction

  // fill the whole bound table in ascending order, with a few repeated bounds
  task automatic test_bound_table_load();
    logic [31:0] level;
    level = $urandom_range(255);
    for (int i = 0; i < NumBins; i++) begin
      send_item(OP_LOAD, i[7:0], level);
      if ($urandom_range(9) != 0) level = level + $urandom_range(24'hFFFF00);
    end
  endtask

  // every mode, the extremes of the sample, edges of bins and an out of order bound
  task automatic test_directed_modes();
    logic [31:0] saved;
    send_item(OP_BIN, 8'd0, 32'd0);
    send_item(OP_BIN, 8'hFF, bound_mem[0]);
    send_item(OP_BIN, 8'd0, bound_mem[0] + 32'd1);
    send_item(OP_BIN, 8'd0, bound_mem[128]);
    send_item(OP_BIN, 8'd0, bound_mem[255]);
    send_item(OP_BIN, 8'd0, bound_mem[255] + 32'd1);   // above the last bound: unbinned
    send_item(OP_BIN, 8'd0, 32'hFFFF_FFFF);
    send_item(OP_READ, 8'd0, 32'd0);
    send_item(OP_READ, 8'd128, 32'hFFFF_FFFF);
    send_item(OP_READ, 8'd255, 32'd0);
    send_item(OP_CLEAR, 8'd0, 32'd0);
    send_item(OP_READ, 8'd0, 32'd0);
    send_item(OP_READ, 8'd128, 32'd0);
    // top bound at full scale, so nothing stays unbinned
    send_item(OP_LOAD, 8'd255, 32'hFFFF_FFFF);
    send_item(OP_BIN, 8'd0, 32'hFFFF_FFFF);
    send_item(OP_READ, 8'd255, 32'd0);
    send_item(OP_LOAD, 8'd0, 32'd0);
    send_item(OP_BIN, 8'd0, 32'd0);
    // a bound out of order in the middle: the search still takes the same steps
    saved = bound_mem[128];
    send_item(OP_LOAD, 8'd128, 32'd0);
    send_item(OP_BIN, 8'd0, bound_mem[130]);
    send_item(OP_BIN, 8'd0, bound_mem[127]);
    send_item(OP_LOAD, 8'd128, saved);
    // saturation of a 32-bit count is out of reach in a run of this length
  endtask

  // search width at its extremes, including zero and values past the table
  task automatic test_bins_in_use_settings();
    logic [CfgW-1:0] settings [9];
    int last;
    settings = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd255, 9'd256, 9'd257, 9'd511, 9'd100};
    settings[8] = 9'($urandom_range(4, 254));
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    foreach (settings[k]) begin
      write_bins_in_use(settings[k]);
      last = bins_active() - 1;
      send_item(OP_BIN, 8'($urandom), bound_mem[0]);
      send_item(OP_BIN, 8'($urandom), bound_mem[last]);
      send_item(OP_BIN, 8'($urandom), bound_mem[last] + 32'd1);
      send_item(OP_BIN, 8'($urandom), pick_sample());
      send_item(OP_READ, last[7:0], $urandom);
    end
  endtask

  // mostly well-formed traffic with random content, plus out of order loads as noise
  task automatic run_random_phase(int n_items);
    int r;
    int i;
    longint lo;
    longint hi;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(99);
      if (r < 68) begin
        send_item(OP_BIN, 8'($urandom), pick_sample());
      end else if (r < 80) begin
        i = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(bins_active() - 1);
        send_item(OP_READ, i[7:0], $urandom);
      end else if (r < 82) begin
        send_item(OP_CLEAR, 8'($urandom), $urandom);
      end else if (r < 97) begin
        // move one bound between its neighbors, keeping the table ascending
        i  = $urandom_range(255);
        lo = (i == 0) ? 0 : longint'(bound_mem[i-1]);
        hi = (i == 255) ? 64'hFFFF_FFFF : longint'(bound_mem[i+1]);
        if (hi < lo) hi = lo;
        send_item(OP_LOAD, i[7:0], 32'(lo + longint'($urandom) % (hi - lo + 1)));
      end else begin
        send_item(OP_LOAD, 8'($urandom), $urandom);
      end
    end
  endtask

  // receiver holds off for a long stretch while items keep coming, so the input stalls
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain();
    recv_holdoff = 150;
    for (int n = 0; n < 30; n++) begin
      if (n % 6 == 5) send_item(OP_READ, 8'($urandom), $urandom);
      else send_item(OP_BIN, 8'($urandom), pick_sample());
    end
  endtask

  // result side: ready pattern, changed at the falling edge
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (recv_holdoff > 0) begin
        m_axis_tready <= 1'b0;
        recv_holdoff--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result checker: every accepted result against the oldest expectation
  initial begin
    bin_result_t want;
    bin_result_t got;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{bin: m_axis_tdata[7:0], hit: m_axis_tuser, count: m_axis_tdata[39:8]};
        n_results++;
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected: bin %0d binned %0b count %0d",
                   $time, got.bin, got.hit, got.count);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.bin !== want.bin) begin
            $display("%0t: matched_bin expected %0d actual %0d", $time, want.bin, got.bin);
            mismatches++;
          end
          if (got.hit !== want.hit) begin
            $display("%0t: was_binned expected %0b actual %0b", $time, want.hit, got.hit);
            mismatches++;
          end
          if (got.count !== want.count) begin
            $display("%0t: bin_count expected %0d actual %0d", $time, want.count, got.count);
            mismatches++;
          end
        end
      end
    end
  end

  // main sequence
  initial begin
    int idle_pcts  [4];
    int stall_pcts [4];
    logic [CfgW-1:0] phase_bins [4];
    idle_pcts  = '{0, 84, 0, 9};
    stall_pcts = '{0, 0, 84, 9};
    phase_bins = '{9'd256, 9'd64, 9'd511, 9'd8};
    phase_bins[1] = 9'($urandom_range(2, 255));
    phase_bins[3] = 9'($urandom_range(2, 255));

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOAD;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    write_bins_in_use(9'd256);
    test_bound_table_load();
    test_directed_modes();
    test_bins_in_use_settings();
    foreach (idle_pcts[p]) begin
      write_bins_in_use(phase_bins[p]);
      send_idle_pct  = idle_pcts[p];
      recv_stall_pct = stall_pcts[p];
      run_random_phase(180);
    end
    test_output_backpressure();

    // let any late or extra result show up before the verdict
    drain();
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d loads, %0d samples (%0d binned), %0d reads, %0d clears",
             n_loads, n_samples, n_binned, n_reads, n_clears);
    $display("%0d results checked over %0d bins_in_use settings", n_results, n_settings);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
